FILE: src/ddsc_pkg.sv
package ddsc_pkg;

  // Command codes on the func field.
  localparam logic [1:0] FUNC_STRAIGHT = 2'd0;
  localparam logic [1:0] FUNC_TURN     = 2'd1;
  localparam logic [1:0] FUNC_MANUAL   = 2'd2;
  localparam logic [1:0] FUNC_SPARE    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KP_STRAIGHT = 3'd0;
  localparam logic [2:0] CFG_KD_STRAIGHT = 3'd1;
  localparam logic [2:0] CFG_KP_TURN     = 3'd2;
  localparam logic [2:0] CFG_KD_TURN     = 3'd3;
  localparam logic [2:0] CFG_SLEW_STEP   = 3'd4;
  localparam logic [2:0] CFG_MAX_DRIVE   = 3'd5;
  localparam logic [2:0] CFG_MOVE_TOL    = 3'd6;
  localparam logic [2:0] CFG_TURN_TOL    = 3'd7;

  // Register reset values.
  localparam logic [15:0] KP_STRAIGHT_RST = 16'd31;
  localparam logic [15:0] KD_STRAIGHT_RST = 16'd26;
  localparam logic [15:0] KP_TURN_RST     = 16'd333;
  localparam logic [15:0] KD_TURN_RST     = 16'd0;
  localparam logic [10:0] SLEW_STEP_RST   = 11'd40;
  localparam logic [10:0] MAX_DRIVE_RST   = 11'd2032;
  localparam logic [15:0] MOVE_TOL_RST    = 16'd240;
  localparam logic [15:0] TURN_TOL_RST    = 16'd16;

  // Error registers start well outside the reset-value settle bands.
  localparam logic signed [31:0] ERR_POS_RST     = 32'sd1584;
  localparam logic signed [31:0] ERR_BEARING_RST = 32'sd15984;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_STRAIGHT,
    MODE_TURN,
    MODE_MANUAL
  } ddsc_mode_t;

  typedef struct packed {
    logic [15:0] kp_straight;
    logic [15:0] kd_straight;
    logic [15:0] kp_turn;
    logic [15:0] kd_turn;
    logic [10:0] slew_step;
    logic [10:0] max_drive;
    logic [15:0] move_tol;
    logic [15:0] turn_tol;
  } ddsc_cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    ddsc_mode_t         mode;
    logic               clr;
    logic signed [31:0] tgt_l;
    logic signed [31:0] tgt_r;
    logic signed [33:0] sum_l;
    logic signed [33:0] sum_r;
    logic signed [31:0] err_b;
  } ddsc_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

endpackage

FILE: src/ddsc_front.sv
module ddsc_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic                  clear_history,
  input  logic signed [31:0]    target_left,
  input  logic signed [31:0]    target_right,
  input  logic signed [31:0]    target_bearing,
  input  logic signed [31:0]    pos_left_a,
  input  logic signed [31:0]    pos_left_b,
  input  logic signed [31:0]    pos_left_c,
  input  logic signed [31:0]    pos_right_a,
  input  logic signed [31:0]    pos_right_b,
  input  logic signed [31:0]    pos_right_c,
  input  logic signed [31:0]    heading,
  input  logic                  full,
  output logic                  push,
  output ddsc_pkg::ddsc_cmd_t   cmd
);

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    unique case (func) inside
      ddsc_pkg::FUNC_STRAIGHT:                       cmd.mode = ddsc_pkg::MODE_STRAIGHT;
      ddsc_pkg::FUNC_TURN:                           cmd.mode = ddsc_pkg::MODE_TURN;
      ddsc_pkg::FUNC_MANUAL, ddsc_pkg::FUNC_SPARE:   cmd.mode = ddsc_pkg::MODE_MANUAL;
    endcase
    cmd.clr   = clear_history;
    cmd.tgt_l = target_left;
    cmd.tgt_r = target_right;
    // Three encoder sums per side; the divide by three is done in the back end.
    cmd.sum_l = 34'(pos_left_a) + 34'(pos_left_b) + 34'(pos_left_c);
    cmd.sum_r = 34'(pos_right_a) + 34'(pos_right_b) + 34'(pos_right_c);
    cmd.err_b = ddsc_pkg::sat32(34'(target_bearing) - 34'(heading));
  end

endmodule

FILE: src/ddsc_fifo.sv
module ddsc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ddsc_pkg::ddsc_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output ddsc_pkg::ddsc_cmd_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ddsc_pkg::ddsc_cmd_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/ddsc_back.sv
module ddsc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  ddsc_pkg::ddsc_cfg_t       cfg,
  input  logic                      head_valid,
  input  ddsc_pkg::ddsc_cmd_t       head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [11:0]        drive_left,
  output logic signed [11:0]        drive_right,
  output logic signed [31:0]        error_left,
  output logic signed [31:0]        error_right,
  output logic signed [31:0]        error_bearing,
  output logic                      settled
);

  // Divide by three one 11-bit digit per step: x < 6144, so x * 5462 >> 14 is exact.
  localparam int          DIV_STEPS   = 3;
  localparam int          DIGIT_W     = 11;
  localparam int          RECIP_SHIFT = 14;
  localparam logic [12:0] RECIP       = 13'd5462;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_PREP,
    ST_MUL,
    ST_SUM,
    ST_TRUNC,
    ST_SLEW,
    ST_FINAL
  } state_t;

  state_t               state;
  logic [1:0]           div_cnt;
  ddsc_pkg::ddsc_mode_t mode;

  logic signed [31:0] tgt_l, tgt_r;
  logic               neg_l, neg_r;
  logic [32:0]        dvd_l, dvd_r;
  logic [1:0]         rem_l, rem_r;

  logic signed [31:0] err_l, err_r, err_b;
  logic signed [31:0] prev_l, prev_r, prev_b;
  logic signed [11:0] drive_l, drive_r;
  logic               settled_w;

  logic signed [32:0] opa_l, opa_r, opb_l, opb_r;
  logic [15:0]        gain_p, gain_d;
  logic signed [49:0] prod_pl, prod_pr, prod_dl, prod_dr;
  logic signed [50:0] tsum_l, tsum_r;
  logic signed [42:0] targ_l, targ_r;
  logic signed [11:0] step_l, step_r;

  logic               out_free;
  logic signed [33:0] abs_l, abs_r;
  logic [12:0]        digit_l, digit_r;
  logic signed [33:0] err_l_wide, err_r_wide;
  logic signed [32:0] pair_sum, pair_adj;
  logic signed [31:0] comb_err;
  logic signed [32:0] diff_l, diff_r, diff_b;
  logic signed [32:0] cand_l, cand_r;
  logic signed [11:0] step_l_next, step_r_next;
  logic signed [11:0] drive_l_next, drive_r_next;

  function automatic logic [12:0] div3_digit(input logic [12:0] x);
    logic [25:0] prod;
    logic [10:0] q;
    logic [12:0] rest;
    prod = 26'(x) * 26'(RECIP);
    q    = prod[RECIP_SHIFT +: DIGIT_W];
    rest = x - 13'(q) * 13'd3;
    return {q, rest[1:0]};
  endfunction

  function automatic logic signed [42:0] trunc256(input logic signed [50:0] t);
    logic adj;
    adj = t[50] && (t[7:0] != 8'd0);
    return $signed(t[50:8]) + $signed({42'd0, adj});
  endfunction

  function automatic logic signed [11:0] slew_cap(input logic signed [43:0] d,
                                                  input logic [10:0] lim);
    logic signed [43:0] lim_s;
    logic signed [43:0] lim_n;
    logic signed [11:0] r;
    lim_s = $signed({33'd0, lim});
    lim_n = -lim_s;
    if (d > lim_s) begin
      r = lim_s[11:0];
    end else if (d < lim_n) begin
      r = lim_n[11:0];
    end else begin
      r = d[11:0];
    end
    return r;
  endfunction

  function automatic logic signed [11:0] drive_cap(input logic signed [32:0] v,
                                                   input logic [10:0] lim);
    logic signed [32:0] lim_s;
    logic signed [32:0] lim_n;
    logic signed [11:0] r;
    lim_s = $signed({22'd0, lim});
    lim_n = -lim_s;
    if (v > lim_s) begin
      r = lim_s[11:0];
    end else if (v < lim_n) begin
      r = lim_n[11:0];
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  function automatic logic within_tol(input logic signed [31:0] v, input logic [15:0] tol);
    logic signed [32:0] t;
    t = $signed({17'd0, tol});
    return (33'(v) <= t) && (33'(v) >= -t);
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && head_valid;

  always_comb begin
    abs_l   = head.sum_l[33] ? -head.sum_l : head.sum_l;
    abs_r   = head.sum_r[33] ? -head.sum_r : head.sum_r;
    digit_l = div3_digit({rem_l, dvd_l[32 -: DIGIT_W]});
    digit_r = div3_digit({rem_r, dvd_r[32 -: DIGIT_W]});

    // After the last digit the dividend register holds the quotient magnitude.
    err_l_wide = neg_l ? 34'(tgt_l) + $signed({1'b0, dvd_l})
                       : 34'(tgt_l) - $signed({1'b0, dvd_l});
    err_r_wide = neg_r ? 34'(tgt_r) + $signed({1'b0, dvd_r})
                       : 34'(tgt_r) - $signed({1'b0, dvd_r});

    // Mean of the two side errors, truncated toward zero.
    pair_sum = 33'(err_l) + 33'(err_r);
    pair_adj = pair_sum + $signed({32'd0, pair_sum[32]});
    comb_err = pair_adj[32:1];

    diff_l = 33'(err_l) - 33'(prev_l);
    diff_r = 33'(err_r) - 33'(prev_r);
    diff_b = 33'(err_b) - 33'(prev_b);

    step_l_next = slew_cap(44'(targ_l) - 44'(drive_l), cfg.slew_step);
    step_r_next = slew_cap(44'(targ_r) - 44'(drive_r), cfg.slew_step);

    if (mode == ddsc_pkg::MODE_MANUAL) begin
      cand_l = 33'(tgt_l);
      cand_r = 33'(tgt_r);
    end else begin
      cand_l = 33'(drive_l) + 33'(step_l);
      cand_r = 33'(drive_r) + 33'(step_r);
    end
    drive_l_next = drive_cap(cand_l, cfg.max_drive);
    drive_r_next = drive_cap(cand_r, cfg.max_drive);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
      drive_l   <= '0;
      drive_r   <= '0;
      err_l     <= ddsc_pkg::ERR_POS_RST;
      err_r     <= ddsc_pkg::ERR_POS_RST;
      err_b     <= ddsc_pkg::ERR_BEARING_RST;
      prev_l    <= '0;
      prev_r    <= '0;
      prev_b    <= '0;
    end else begin
      if (state == ST_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            mode      <= head.mode;
            tgt_l     <= head.tgt_l;
            tgt_r     <= head.tgt_r;
            neg_l     <= head.sum_l[33];
            neg_r     <= head.sum_r[33];
            dvd_l     <= abs_l[32:0];
            dvd_r     <= abs_r[32:0];
            rem_l     <= '0;
            rem_r     <= '0;
            div_cnt   <= '0;
            settled_w <= 1'b0;
            if (head.clr) begin
              prev_l <= '0;
              prev_r <= '0;
              prev_b <= '0;
            end
            unique case (head.mode)
              ddsc_pkg::MODE_STRAIGHT: state <= ST_DIV;
              ddsc_pkg::MODE_TURN: begin
                err_b <= head.err_b;
                state <= ST_PREP;
              end
              default: state <= ST_FINAL;
            endcase
          end
        end
        ST_DIV: begin
          dvd_l <= {dvd_l[32-DIGIT_W:0], digit_l[12:2]};
          dvd_r <= {dvd_r[32-DIGIT_W:0], digit_r[12:2]};
          rem_l <= digit_l[1:0];
          rem_r <= digit_r[1:0];
          if (div_cnt == 2'(DIV_STEPS - 1)) begin
            state <= ST_ERR;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        ST_ERR: begin
          err_l <= ddsc_pkg::sat32(err_l_wide);
          err_r <= ddsc_pkg::sat32(err_r_wide);
          state <= ST_PREP;
        end
        ST_PREP: begin
          if (mode == ddsc_pkg::MODE_TURN) begin
            // Opposite drive: the right side works on the negated error terms.
            opa_l     <= 33'(err_b);
            opa_r     <= -33'(err_b);
            opb_l     <= diff_b;
            opb_r     <= -diff_b;
            gain_p    <= cfg.kp_turn;
            gain_d    <= cfg.kd_turn;
            prev_b    <= err_b;
            settled_w <= within_tol(err_b, cfg.turn_tol);
          end else begin
            opa_l     <= 33'(comb_err);
            opa_r     <= 33'(comb_err);
            opb_l     <= diff_l;
            opb_r     <= diff_r;
            gain_p    <= cfg.kp_straight;
            gain_d    <= cfg.kd_straight;
            prev_l    <= err_l;
            prev_r    <= err_r;
            settled_w <= within_tol(err_l, cfg.move_tol) && within_tol(err_r, cfg.move_tol);
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_pl <= 50'(opa_l) * 50'($signed({1'b0, gain_p}));
          prod_pr <= 50'(opa_r) * 50'($signed({1'b0, gain_p}));
          prod_dl <= 50'(opb_l) * 50'($signed({1'b0, gain_d}));
          prod_dr <= 50'(opb_r) * 50'($signed({1'b0, gain_d}));
          state   <= ST_SUM;
        end
        ST_SUM: begin
          tsum_l <= 51'(prod_pl) + 51'(prod_dl);
          tsum_r <= 51'(prod_pr) + 51'(prod_dr);
          state  <= ST_TRUNC;
        end
        ST_TRUNC: begin
          targ_l <= trunc256(tsum_l);
          targ_r <= trunc256(tsum_r);
          state  <= ST_SLEW;
        end
        ST_SLEW: begin
          step_l <= step_l_next;
          step_r <= step_r_next;
          state  <= ST_FINAL;
        end
        ST_FINAL: begin
          if (out_free) begin
            drive_l       <= drive_l_next;
            drive_r       <= drive_r_next;
            drive_left    <= drive_l_next;
            drive_right   <= drive_r_next;
            error_left    <= err_l;
            error_right   <= err_r;
            error_bearing <= err_b;
            settled       <= settled_w;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_final_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && out_free) |=>
      (out_valid && drive_left == drive_l && drive_right == drive_r))
    else $error("result register does not match the drive state");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_IDLE))
    else $error("dequeued request did not start");

  a_step_in_band: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SLEW) |=>
      (step_l <= $signed({1'b0, $past(cfg.slew_step)})
       && step_l >= -$signed({1'b0, $past(cfg.slew_step)})
       && step_r <= $signed({1'b0, $past(cfg.slew_step)})
       && step_r >= -$signed({1'b0, $past(cfg.slew_step)})))
    else $error("slew step exceeds the configured limit");
`endif

endmodule

FILE: src/diff_drive_pd_slew_controller.sv
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  func, clear_history, targets, six encoders, heading
// out      out_valid/out_stall  drive_left/right, error_left/right/bearing, settled
// cfg      cfg_write            cfg_index selects the register, cfg_data the value
//
// A request is classified on entry and waits in a small queue; the back-end
// sequencer takes a straight request through a three-digit divide by three and the
// error, PD, slew and final stages, a turn one from PD on, a manual one to final only.
// Reset is synchronous and active high; it empties the queue and restores the
// configuration, drive values and error history to their documented start values.
// A stalled output holds its result while new requests still enter the queue.
module diff_drive_pd_slew_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic               clear_history,
  input  logic signed [31:0] target_left,
  input  logic signed [31:0] target_right,
  input  logic signed [31:0] target_bearing,
  input  logic signed [31:0] pos_left_a,
  input  logic signed [31:0] pos_left_b,
  input  logic signed [31:0] pos_left_c,
  input  logic signed [31:0] pos_right_a,
  input  logic signed [31:0] pos_right_b,
  input  logic signed [31:0] pos_right_c,
  input  logic signed [31:0] heading,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] drive_left,
  output logic signed [11:0] drive_right,
  output logic signed [31:0] error_left,
  output logic signed [31:0] error_right,
  output logic signed [31:0] error_bearing,
  output logic               settled
);

  // The configuration is held here and handed to the back end as one bundle.
  // Writes are expected only while no request is in flight.
  ddsc_pkg::ddsc_cfg_t cfg;

  // Queue traffic between the classifier and the sequencer.
  logic                push;
  logic                full;
  logic                pop;
  logic                head_valid;
  ddsc_pkg::ddsc_cmd_t push_cmd;
  ddsc_pkg::ddsc_cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_straight <= ddsc_pkg::KP_STRAIGHT_RST;
      cfg.kd_straight <= ddsc_pkg::KD_STRAIGHT_RST;
      cfg.kp_turn     <= ddsc_pkg::KP_TURN_RST;
      cfg.kd_turn     <= ddsc_pkg::KD_TURN_RST;
      cfg.slew_step   <= ddsc_pkg::SLEW_STEP_RST;
      cfg.max_drive   <= ddsc_pkg::MAX_DRIVE_RST;
      cfg.move_tol    <= ddsc_pkg::MOVE_TOL_RST;
      cfg.turn_tol    <= ddsc_pkg::TURN_TOL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddsc_pkg::CFG_KP_STRAIGHT: cfg.kp_straight <= cfg_data;
        ddsc_pkg::CFG_KD_STRAIGHT: cfg.kd_straight <= cfg_data;
        ddsc_pkg::CFG_KP_TURN:     cfg.kp_turn     <= cfg_data;
        ddsc_pkg::CFG_KD_TURN:     cfg.kd_turn     <= cfg_data;
        ddsc_pkg::CFG_SLEW_STEP:   cfg.slew_step   <= cfg_data[10:0];
        ddsc_pkg::CFG_MAX_DRIVE:   cfg.max_drive   <= cfg_data[10:0];
        ddsc_pkg::CFG_MOVE_TOL:    cfg.move_tol    <= cfg_data;
        ddsc_pkg::CFG_TURN_TOL:    cfg.turn_tol    <= cfg_data;
      endcase
    end
  end

  // The front end sums each side's encoders, forms the saturated heading
  // error and decodes the command, so that the queue carries ready operands.
  ddsc_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .clear_history  (clear_history),
    .target_left    (target_left),
    .target_right   (target_right),
    .target_bearing (target_bearing),
    .pos_left_a     (pos_left_a),
    .pos_left_b     (pos_left_b),
    .pos_left_c     (pos_left_c),
    .pos_right_a    (pos_right_a),
    .pos_right_b    (pos_right_b),
    .pos_right_c    (pos_right_c),
    .heading        (heading),
    .full           (full),
    .push           (push),
    .cmd            (push_cmd)
  );

  // The queue lets requests keep arriving while the sequencer is busy or
  // its result is held by a stalled consumer.
  ddsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end owns the control state: drive values, error registers and
  // error history. It runs the averaging, the PD law, the slew limit and the
  // final clamp, and keeps the result in its output register until taken.
  ddsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_left    (drive_left),
    .drive_right   (drive_right),
    .error_left    (error_left),
    .error_right   (error_right),
    .error_bearing (error_bearing),
    .settled       (settled)
  );

endmodule
